@@ src/dq_pkg.sv @@
`default_nettype none

package dq_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int VALUE_W  = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    localparam logic [CNT_W-1:0] OCC_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_M1   = CNT_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_ZERO = '0;
    localparam logic [CNT_W:0]   CAP_EXT  = (CNT_W + 1)'(CAPACITY);

    // One access of the entry store per cycle in each direction.
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [VALUE_W-1:0] wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } dq_mem_req_t;

    // Ring position base + off, folded back into the store.
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
        if (sum >= CAP_EXT) begin
            sum = sum - CAP_EXT;
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ src/dq_store.sv @@
`default_nettype none

module dq_store
    import dq_pkg::*;
(
    input  wire logic               aclk,
    input  wire dq_mem_req_t        req,
    output logic [VALUE_W-1:0]      rd_data
);

    logic [VALUE_W-1:0] mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // The read data holds while no read is issued, so a stalled result keeps its value.
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/dq_ctrl.sv @@
`default_nettype none

module dq_ctrl
    import dq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [OP_W-1:0]      s_op,
    input  wire logic [VALUE_W-1:0]   s_value,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [VALUE_W-1:0]        m_value,
    output logic [STATUS_W-1:0]       m_status,
    output logic                      m_last,
    output dq_mem_req_t               mem_req,
    input  wire logic [VALUE_W-1:0]   rd_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_DUMP = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [CNT_W-1:0]    dump_cnt_reg, dump_cnt_next;
    logic                m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]  m_value_reg, m_value_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic                m_last_reg, m_last_next;

    logic out_free;
    logic accept;
    logic dump_last;
    logic [IDX_W-1:0] new_front;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign dump_last = (dump_cnt_reg + CNT_ONE) == occ_reg;
    assign new_front = ring_add(front_reg, CAP_M1);

    assign m_tvalid = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;
    assign m_last   = m_last_reg;

    always_comb begin
        state_next    = state_reg;
        front_next    = front_reg;
        occ_next      = occ_reg;
        dump_cnt_next = dump_cnt_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        mem_req       = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            m_valid_next = 1'b1;
                            m_value_next = '0;
                            m_last_next  = 1'b1;
                            if (occ_reg >= OCC_FULL) begin
                                m_status_next = STAT_FULL;
                            end else begin
                                m_status_next = STAT_OK;
                                mem_req.we    = 1'b1;
                                mem_req.wdata = s_value;
                                occ_next      = occ_reg + CNT_ONE;
                                if (s_op == OP_PUSH_FRONT) begin
                                    mem_req.waddr = new_front;
                                    front_next    = new_front;
                                end else begin
                                    mem_req.waddr = ring_add(front_reg, occ_reg);
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK, OP_DUMP: begin
                            if (occ_reg == CNT_ZERO) begin
                                m_valid_next  = 1'b1;
                                m_value_next  = '0;
                                m_status_next = STAT_EMPTY;
                                m_last_next   = 1'b1;
                            end else if (s_op == OP_DUMP) begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = front_reg;
                                dump_cnt_next = CNT_ZERO;
                                state_next    = S_DUMP;
                            end else begin
                                mem_req.re = 1'b1;
                                occ_next   = occ_reg - CNT_ONE;
                                state_next = S_POP;
                                if (s_op == OP_POP_FRONT) begin
                                    mem_req.raddr = front_reg;
                                    front_next    = ring_add(front_reg, CNT_ONE);
                                end else begin
                                    mem_req.raddr = ring_add(front_reg, occ_reg - CNT_ONE);
                                end
                            end
                        end
                        default: begin
                            // Undefined operations are dropped without a result.
                        end
                    endcase
                end
            end
            S_POP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = rd_data;
                    m_status_next = STAT_OK;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_DUMP: begin
                // Each time an entry moves to the output, the read of the next one is issued.
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = rd_data;
                    m_status_next = STAT_OK;
                    m_last_next   = dump_last;
                    if (dump_last) begin
                        state_next = S_IDLE;
                    end else begin
                        dump_cnt_next = dump_cnt_reg + CNT_ONE;
                        mem_req.re    = 1'b1;
                        mem_req.raddr = ring_add(front_reg, dump_cnt_reg + CNT_ONE);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dump_cnt_reg <= dump_cnt_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

endmodule

`default_nettype wire

@@ src/double_ended_queue.sv @@
// Double-ended queue of 32-bit signed values held in a ring of CAPACITY entries.
// Requests arrive on the s_ channel: s_tuser carries the operation (push front,
// pop front, push back, pop back, dump) and s_tdata the value to push. Results
// leave on the m_ channel: m_tdata is the popped or dumped value, m_tuser the
// status (ok, empty, full) and m_tlast marks the final result of a request.
// A push writes the store in the cycle it is accepted; its result is valid the
// next cycle, so pushes and rejected requests run at one item per cycle while
// m_tready is high. A pop reads the store, whose read port is registered, and
// its result moves from S_POP into the output register. A dump emits its first
// entry the same way and then one entry per cycle while m_tready is high, front
// to back, one result for each entry that the queue holds.
// One request is in work at a time; s_tready is low while a pop or dump waits
// on the store. A result waits in the output register while m_tready is low,
// and the walk of a dump pauses with it. Reset empties the queue at once; the
// store itself is not cleared, since no entry is read before it was written.
// Undefined operations are accepted and give no result.
`default_nettype none

module double_ended_queue
    import dq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // value[31:0]
    input  wire logic [7:0]  s_tuser,  // operation[2:0], zero above
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // result_value[31:0]
    output logic [7:0]       m_tuser,  // status[1:0], zero above
    output logic             m_tlast
);

    dq_mem_req_t         mem_req;
    logic [VALUE_W-1:0]  rd_data;
    logic [STATUS_W-1:0] status;

    dq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser[OP_W-1:0]),
        .s_value  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_value  (m_tdata),
        .m_status (status),
        .m_last   (m_tlast),
        .mem_req  (mem_req),
        .rd_data  (rd_data)
    );

    dq_store u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign m_tuser = {{(8 - STATUS_W){1'b0}}, status};

endmodule

`default_nettype wire
